// ===== rtl/core/hri_pkg.sv =====
// Shared types, constants and register codes of the Halton radical inverse block.
package hri_pkg;

    localparam int BASE_W            = 16;
    localparam int AXIS_W            = 2;
    localparam int INDEX_W           = 32;
    localparam int FRACTION_W        = 32;
    localparam int REG_COUNT         = 4;
    localparam int REG_IDX_W         = 2;
    localparam int AXES_DEF          = 4;
    localparam int INDEX_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BASE_AXIS0 = 2'd0,
        REG_BASE_AXIS1 = 2'd1,
        REG_BASE_AXIS2 = 2'd2,
        REG_BASE_AXIS3 = 2'd3
    } hri_reg_t;

    // Control that travels with every word through the pipeline.
    typedef struct packed {
        logic              valid;
        logic              force_zero;
        logic [BASE_W-1:0] base;
    } hri_ctl_t;

    function automatic logic [BASE_W-1:0] base_reset(input logic [REG_IDX_W-1:0] idx);
        logic [BASE_W-1:0] val;
        case (hri_reg_t'(idx))
            REG_BASE_AXIS0: val = 16'd2;
            REG_BASE_AXIS1: val = 16'd3;
            REG_BASE_AXIS2: val = 16'd5;
            REG_BASE_AXIS3: val = 16'd7;
            default:        val = 16'd2;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/hri_digits.sv =====
// Binary to base-b digit conversion, one index bit per pipeline stage.
module hri_digits #(
    parameter int INDEX_BITS = hri_pkg::INDEX_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  hri_pkg::hri_ctl_t                             in_ctl,
    input  logic [INDEX_BITS-1:0]                         in_index,
    output hri_pkg::hri_ctl_t                             out_ctl,
    output logic [INDEX_BITS-1:0][hri_pkg::BASE_W-1:0]    out_digits
);

    localparam int BW = hri_pkg::BASE_W;

    typedef logic [INDEX_BITS-1:0][BW-1:0] digits_t;

    // Doubles the base-b digit vector and adds one bit. A digit carries out
    // when twice it plus the incoming carry reaches the base.
    function automatic digits_t dabble_step(input digits_t d, input logic [BW-1:0] b,
                                            input logic bin);
        digits_t     r;
        logic        c;
        logic        g;
        logic        p;
        logic [BW:0] t;
        c = bin;
        for (int j = 0; j < INDEX_BITS; j++) begin
            g = ({d[j], 1'b0} >= {1'b0, b});
            p = ({d[j], 1'b1} >= {1'b0, b});
            t = {d[j], c};
            if (g || (p && c)) begin
                t = t - {1'b0, b};
                c = 1'b1;
            end
            else begin
                c = 1'b0;
            end
            r[j] = t[BW-1:0];
        end
        return r;
    endfunction

    hri_pkg::hri_ctl_t     ctl_reg [0:INDEX_BITS];
    digits_t               dig_reg [0:INDEX_BITS];
    logic [INDEX_BITS-1:0] idx_reg [0:INDEX_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg[0] <= in_index;
        dig_reg[0] <= '0;
    end

    genvar s;
    for (s = 0; s < INDEX_BITS; s++)
    begin : g_stage
        digits_t dig_next;

        always_comb
        begin
            dig_next = dabble_step(dig_reg[s], ctl_reg[s].base, idx_reg[s][INDEX_BITS-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            dig_reg[s+1] <= dig_next;
        end

        if (s < INDEX_BITS - 1)
        begin : g_idx
            always_ff @(posedge clk)
            begin
                idx_reg[s+1] <= idx_reg[s] << 1;
            end
        end
    end

    assign out_ctl    = ctl_reg[INDEX_BITS];
    assign out_digits = dig_reg[INDEX_BITS];

endmodule

// ===== rtl/core/hri_horner.sv =====
// Builds the mirrored digit value and the matching power of the base, one digit per stage.
module hri_horner #(
    parameter int INDEX_BITS = hri_pkg::INDEX_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  hri_pkg::hri_ctl_t                             in_ctl,
    input  logic [INDEX_BITS-1:0][hri_pkg::BASE_W-1:0]    in_digits,
    output hri_pkg::hri_ctl_t                             out_ctl,
    output logic [INDEX_BITS+hri_pkg::BASE_W-1:0]         out_value,
    output logic [INDEX_BITS+hri_pkg::BASE_W-1:0]         out_power
);

    localparam int BW = hri_pkg::BASE_W;
    localparam int W  = INDEX_BITS + BW;

    typedef logic [INDEX_BITS-1:0][BW-1:0] digits_t;

    hri_pkg::hri_ctl_t     ctl_reg [0:INDEX_BITS];
    logic [W-1:0]          val_reg [0:INDEX_BITS];
    logic [W-1:0]          pow_reg [0:INDEX_BITS];
    digits_t               dig_reg [0:INDEX_BITS-1];
    logic [INDEX_BITS-1:0] act_reg [0:INDEX_BITS-1];
    logic [INDEX_BITS-1:0] act_next;

    // A digit position takes part when it or any higher digit is nonzero.
    always_comb
    begin
        logic any;
        any = 1'b0;
        for (int j = INDEX_BITS - 1; j >= 0; j--) begin
            any         = any | (|in_digits[j]);
            act_next[j] = any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg[0] <= in_digits;
        act_reg[0] <= act_next;
        val_reg[0] <= '0;
        pow_reg[0] <= {{(W-1){1'b0}}, 1'b1};
    end

    genvar s;
    for (s = 0; s < INDEX_BITS; s++)
    begin : g_stage
        logic [W+BW-1:0] val_prod;
        logic [W+BW-1:0] pow_prod;
        logic [W-1:0]    val_next;
        logic [W-1:0]    pow_next;

        always_comb
        begin
            val_prod = {{BW{1'b0}}, val_reg[s]} * {{W{1'b0}}, ctl_reg[s].base}
                     + {{W{1'b0}}, dig_reg[s][s]};
            pow_prod = {{BW{1'b0}}, pow_reg[s]} * {{W{1'b0}}, ctl_reg[s].base};
            if (act_reg[s][s])
            begin
                val_next = val_prod[W-1:0];
                pow_next = pow_prod[W-1:0];
            end
            else
            begin
                val_next = val_reg[s];
                pow_next = pow_reg[s];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[s+1] <= val_next;
            pow_reg[s+1] <= pow_next;
        end

        if (s < INDEX_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                dig_reg[s+1] <= dig_reg[s];
                act_reg[s+1] <= act_reg[s];
            end
        end
    end

    assign out_ctl   = ctl_reg[INDEX_BITS];
    assign out_value = val_reg[INDEX_BITS];
    assign out_power = pow_reg[INDEX_BITS];

endmodule

// ===== rtl/core/hri_divide.sv =====
// Restoring fraction divider, one quotient bit per pipeline stage.
module hri_divide #(
    parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hri_pkg::hri_ctl_t                     in_ctl,
    input  logic [INDEX_BITS+hri_pkg::BASE_W-1:0] in_value,
    input  logic [INDEX_BITS+hri_pkg::BASE_W-1:0] in_power,
    output logic                                  out_valid,
    output logic [FRACTION_BITS-1:0]              out_quotient
);

    localparam int W = INDEX_BITS + hri_pkg::BASE_W;

    hri_pkg::hri_ctl_t        ctl_reg [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] q_reg   [0:FRACTION_BITS];
    logic [W-1:0]             rem_reg [0:FRACTION_BITS-1];
    logic [W-1:0]             pow_reg [0:FRACTION_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= in_value;
        pow_reg[0] <= in_power;
        q_reg[0]   <= '0;
    end

    genvar s;
    for (s = 0; s < FRACTION_BITS; s++)
    begin : g_stage
        logic [W:0]               shifted;
        logic                     fits;
        logic [W:0]               diff;
        logic [W-1:0]             rem_next;
        logic [FRACTION_BITS-1:0] q_next;

        // The remainder stays below the power, so twice it fits in one more bit.
        always_comb
        begin
            shifted  = {rem_reg[s], 1'b0};
            fits     = (shifted >= {1'b0, pow_reg[s]});
            diff     = shifted - {1'b0, pow_reg[s]};
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            q_next   = {q_reg[s][FRACTION_BITS-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[s+1] <= q_next;
        end

        if (s < FRACTION_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s+1] <= rem_next;
                pow_reg[s+1] <= pow_reg[s];
            end
        end
    end

    assign out_valid    = ctl_reg[FRACTION_BITS].valid;
    assign out_quotient = ctl_reg[FRACTION_BITS].force_zero ? '0 : q_reg[FRACTION_BITS];

endmodule

// ===== rtl/core/halton_radical_inverse_top.sv =====
// Top level of the Halton radical inverse block: base registers and the three pipeline sections.
//
// A word (axis, sample_index) is taken at every clock edge where start is high; busy is
// always low, so one word per cycle streams in without gaps. Each word's radical inverse
// appears on fraction with done high for one cycle, in order. The sections have one
// stage per index bit converting to base-b digits, one stage per digit mirroring them,
// and one stage per fraction bit dividing. The receiver cannot stall the block. The user
// must write base registers through cfg_we/cfg_index/cfg_data only while no word is in
// flight; the block itself does not enforce it.
module halton_radical_inverse_top #(
    parameter int AXES          = hri_pkg::AXES_DEF,
    parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
    parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hri_pkg::AXIS_W-1:0]        axis,
    input  logic [hri_pkg::INDEX_W-1:0]       sample_index,
    input  logic                              cfg_we,
    input  logic [hri_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [hri_pkg::BASE_W-1:0]        cfg_data,
    output logic                              done,
    output logic [hri_pkg::FRACTION_W-1:0]    fraction
);

    localparam int BW  = hri_pkg::BASE_W;
    localparam int W   = INDEX_BITS + BW;
    localparam int LAT = 2 * INDEX_BITS + FRACTION_BITS + 3;

    logic [BW-1:0]                    base_reg [0:hri_pkg::REG_COUNT-1];
    logic [INDEX_BITS-1:0]            index_in;
    logic [BW-1:0]                    base_sel;
    hri_pkg::hri_ctl_t                in_ctl;
    hri_pkg::hri_ctl_t                dig_ctl;
    logic [INDEX_BITS-1:0][BW-1:0]    dig_digits;
    hri_pkg::hri_ctl_t                hor_ctl;
    logic [W-1:0]                     hor_value;
    logic [W-1:0]                     hor_power;
    logic [FRACTION_BITS-1:0]         quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hri_pkg::REG_COUNT; i++) begin
                base_reg[i] <= hri_pkg::base_reset(hri_pkg::REG_IDX_W'(i));
            end
        end
        else if (cfg_we)
        begin
            base_reg[cfg_index] <= cfg_data;
        end
    end

    if (INDEX_BITS <= hri_pkg::INDEX_W)
    begin : g_idx_narrow
        assign index_in = sample_index[INDEX_BITS-1:0];
    end
    else
    begin : g_idx_wide
        assign index_in = {{(INDEX_BITS-hri_pkg::INDEX_W){1'b0}}, sample_index};
    end

    // A missing axis or a base below two gives a zero fraction.
    always_comb
    begin
        base_sel          = base_reg[axis];
        in_ctl.valid      = start;
        in_ctl.base       = base_sel;
        in_ctl.force_zero = (int'(axis) >= AXES) || (base_sel < 16'd2);
    end

    assign busy = 1'b0;

    hri_digits #(
        .INDEX_BITS (INDEX_BITS)
    ) u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (in_ctl),
        .in_index   (index_in),
        .out_ctl    (dig_ctl),
        .out_digits (dig_digits)
    );

    hri_horner #(
        .INDEX_BITS (INDEX_BITS)
    ) u_horner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (dig_ctl),
        .in_digits  (dig_digits),
        .out_ctl    (hor_ctl),
        .out_value  (hor_value),
        .out_power  (hor_power)
    );

    hri_divide #(
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divide (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctl       (hor_ctl),
        .in_value     (hor_value),
        .in_power     (hor_power),
        .out_valid    (done),
        .out_quotient (quotient)
    );

    if (FRACTION_BITS >= hri_pkg::FRACTION_W)
    begin : g_frac_wide
        assign fraction = quotient[hri_pkg::FRACTION_W-1:0];
    end
    else
    begin : g_frac_narrow
        assign fraction = {{(hri_pkg::FRACTION_W-FRACTION_BITS){1'b0}}, quotient};
    end

    function automatic logic digits_below(input logic [INDEX_BITS-1:0][BW-1:0] d,
                                          input logic [BW-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < INDEX_BITS; j++) begin
            ok = ok & (d[j] < b);
        end
        return ok;
    endfunction

`ifndef SYNTHESIS
    // Every converted digit must be a legal digit of its base.
    a_digits_legal: assert property (@(posedge clk) disable iff (!rst_n)
        dig_ctl.valid && !dig_ctl.force_zero |-> digits_below(dig_digits, dig_ctl.base))
        else $error("digit conversion produced a digit not below the base");

    // The mirrored value must stay below the base power, so the quotient fits.
    a_value_below_power: assert property (@(posedge clk) disable iff (!rst_n)
        hor_ctl.valid && !hor_ctl.force_zero |-> hor_value < hor_power)
        else $error("mirrored value is not below the base power");

    // A result word appears only where a word was taken exactly the pipeline depth earlier.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without a matching input word");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for the Halton radical inverse block: directed and random words with a scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 120;
    localparam int RANDOM_WORDS = 750;

    class fraction_board_t;
        logic [hri_pkg::BASE_W-1:0]     base_copy [hri_pkg::REG_COUNT];
        logic [hri_pkg::FRACTION_W-1:0] expected_q [$];
        int                             errors;
        int                             words_seen;
        int                             fractions_seen;

        function new();
            base_copy[0] = 16'd2;
            base_copy[1] = 16'd3;
            base_copy[2] = 16'd5;
            base_copy[3] = 16'd7;
            errors = 0;
            words_seen = 0;
            fractions_seen = 0;
        endfunction

        function void set_base(hri_pkg::hri_reg_t idx, logic [hri_pkg::BASE_W-1:0] val);
            base_copy[idx] = val;
        endfunction

        // Mirror the base-b digits of n about the radix point, in 0.32 fixed point.
        function logic [hri_pkg::FRACTION_W-1:0] mirror_digits(
            logic [hri_pkg::INDEX_W-1:0] n,
            logic [hri_pkg::BASE_W-1:0] b);
            logic [hri_pkg::BASE_W-1:0] dig [hri_pkg::INDEX_W];
            logic [hri_pkg::INDEX_W-1:0] rest;
            logic [63:0] acc;
            int cnt;
            if (b < 2)
                return '0;
            rest = n;
            cnt = 0;
            while (rest != 0) begin
                dig[cnt] = hri_pkg::BASE_W'(rest % b);
                rest = rest / b;
                cnt++;
            end
            acc = 0;
            while (cnt > 0) begin
                cnt--;
                acc = (acc + (64'(dig[cnt]) << hri_pkg::FRACTION_W)) / b;
            end
            return acc[hri_pkg::FRACTION_W-1:0];
        endfunction

        function void note_word(logic [hri_pkg::AXIS_W-1:0] ax,
                                logic [hri_pkg::INDEX_W-1:0] idx);
            logic [hri_pkg::FRACTION_W-1:0] f;
            f = '0;
            if (ax < hri_pkg::AXES_DEF)
                f = mirror_digits(idx, base_copy[ax]);
            expected_q.push_back(f);
            words_seen++;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_fraction(logic [hri_pkg::FRACTION_W-1:0] got);
            logic [hri_pkg::FRACTION_W-1:0] want;
            fractions_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected fraction %h", got));
            end
            else begin
                want = expected_q.pop_front();
                if (got !== want)
                    report($sformatf("fraction %h, expected %h", got, want));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [hri_pkg::AXIS_W-1:0]     axis = '0;
    logic [hri_pkg::INDEX_W-1:0]    sample_index = '0;
    logic                           cfg_we = 1'b0;
    logic [hri_pkg::REG_IDX_W-1:0]  cfg_index = '0;
    logic [hri_pkg::BASE_W-1:0]     cfg_data = '0;
    logic                           done;
    logic [hri_pkg::FRACTION_W-1:0] fraction;

    fraction_board_t board = new();
    int  cycles = 0;
    bit  calm = 1'b0;

    halton_radical_inverse_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .axis(axis), .sample_index(sample_index),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .fraction(fraction)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_fraction(fraction);
    end

    // Present one word and hold it until the block takes it, then maybe idle a while.
    task send_word(logic [hri_pkg::AXIS_W-1:0] ax, logic [hri_pkg::INDEX_W-1:0] idx);
        bit taken;
        start <= 1'b1;
        axis <= ax;
        sample_index <= idx;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        board.note_word(ax, idx);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Stop offering words, then wait until every expected fraction has come back.
    task drain();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_base(hri_pkg::hri_reg_t idx, logic [hri_pkg::BASE_W-1:0] val);
        start <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_base(idx, val);
    endtask

    task set_bases(logic [hri_pkg::BASE_W-1:0] b0, logic [hri_pkg::BASE_W-1:0] b1,
                   logic [hri_pkg::BASE_W-1:0] b2, logic [hri_pkg::BASE_W-1:0] b3);
        drain();
        write_base(hri_pkg::REG_BASE_AXIS0, b0);
        write_base(hri_pkg::REG_BASE_AXIS1, b1);
        write_base(hri_pkg::REG_BASE_AXIS2, b2);
        write_base(hri_pkg::REG_BASE_AXIS3, b3);
    endtask

    task directed_words();
        logic [hri_pkg::INDEX_W-1:0] pat [6];
        pat[0] = 32'h0000_0000;
        pat[1] = 32'h0000_0001;
        pat[2] = 32'hFFFF_FFFF;
        pat[3] = 32'h8000_0000;
        pat[4] = 32'h5555_5555;
        pat[5] = 32'hAAAA_AAAA;
        for (int a = 0; a < hri_pkg::AXES_DEF; a++)
            for (int p = 0; p < 6; p++)
                send_word(hri_pkg::AXIS_W'(a), pat[p]);
    endtask

    task random_words(int count);
        logic [hri_pkg::INDEX_W-1:0] idx;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: idx = $urandom_range(0, 255);
                1: idx = $urandom_range(0, 65535);
                default: idx = $urandom;
            endcase
            send_word(hri_pkg::AXIS_W'($urandom_range(0, 3)), idx);
        end
    endtask

    function logic [hri_pkg::BASE_W-1:0] any_base();
        return $urandom_range(0, 9) == 0 ? hri_pkg::BASE_W'($urandom_range(0, 1))
                                         : hri_pkg::BASE_W'($urandom_range(2, 65535));
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset bases first, then the extremes, then bases below two, then other primes, then random bases.
        directed_words();
        random_words(RANDOM_WORDS / 5);
        set_bases(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFD);
        directed_words();
        random_words(RANDOM_WORDS / 5);
        set_bases(16'd0, 16'd1, 16'd2, 16'd65521);
        directed_words();
        random_words(RANDOM_WORDS / 5);
        set_bases(16'd11, 16'd13, 16'd17, 16'd257);
        random_words(RANDOM_WORDS / 5);
        set_bases(any_base(), any_base(), any_base(), any_base());
        calm = 1'b1;
        random_words(RANDOM_WORDS / 5);
        start <= 1'b0;

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d fractions never arrived", board.pending()));
        $display("covered %0d words and %0d fractions over five base settings",
                 board.words_seen, board.fractions_seen);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
